// File: design/lkv_pkg.sv
// Package with the shared constants, payload types and memory request types of the LRU cache.
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] write_value;
  } cmd_t;

  typedef struct packed {
    logic              found;
    logic signed [VAL_W-1:0] read_value;
    logic              evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } rsp_t;

  // One entry of the tag memory: its key and its recency rank.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] rank;
  } meta_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    meta_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } meta_req_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } val_req_t;

endpackage

// File: design/lkv_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module lkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lkv_engine.sv
// Sequencer that scans the tag memory, decides hit, fill or eviction, and rewrites the ranks.
`timescale 1ns / 1ps

module lkv_engine import lkv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  cmd_t                  cmd_i,
  input  logic [CAP_W-1:0]      cap_i,
  output logic                  done_o,
  output rsp_t                  rsp_o,
  output meta_req_t             meta_req_o,
  input  meta_t                 meta_rdata_i,
  output val_req_t              val_req_o,
  input  logic [DATA_WIDTH-1:0] val_rdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]       occ_q, occ_d;
  logic                   done_q, done_d;

  cmd_t             cmd_q, cmd_d;
  rsp_t             rsp_q, rsp_d;
  logic             hit_q, hit_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0] hit_rank_q, hit_rank_d;
  logic             lru_seen_q, lru_seen_d;
  logic [IDX_W-1:0] lru_idx_q, lru_idx_d;
  logic [IDX_W-1:0] lru_rank_q, lru_rank_d;
  logic [KEY_W-1:0] lru_key_q, lru_key_d;
  logic [IDX_W-1:0] tgt_q, tgt_d;
  logic [IDX_W-1:0] thr_q, thr_d;
  logic             inc_all_q, inc_all_d;
  logic             ins_q, ins_d;
  logic             rd_hit_q, rd_hit_d;
  logic             evict_q, evict_d;

  logic [CNT_W-1:0]         cnt_m1;
  logic [IDX_W-1:0]         di;
  logic                     last;
  logic                     full;
  logic [IDX_W-1:0]         free_idx;
  logic [DATA_WIDTH+31:0]   val_wide;
  logic [DATA_WIDTH+31:0]   rd_wide;
  meta_t                    upd_word;

  assign cnt_m1   = cnt_q - 1'b1;
  assign di       = cnt_m1[IDX_W-1:0];
  assign last     = (cnt_q == CNT_W'(MAX_ENTRIES));
  assign val_wide = {{DATA_WIDTH{1'b0}}, cmd_q.write_value};
  assign rd_wide  = {32'd0, val_rdata_i};

  // A new key evicts once the occupancy reaches the clamped capacity.
  always_comb begin
    if (cap_i == '0) begin
      full = (occ_q != '0);
    end else if (int'(cap_i) > MAX_ENTRIES) begin
      full = (int'(occ_q) >= MAX_ENTRIES);
    end else begin
      full = (int'(occ_q) >= int'(cap_i));
    end
  end

  // Lowest free entry.
  always_comb begin
    free_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // Rewritten tag word during the update sweep.
  always_comb begin
    upd_word = meta_rdata_i;
    if (di == tgt_q) begin
      upd_word.rank = '0;
      if (ins_q) begin
        upd_word.key = cmd_q.lookup_key;
      end
    end else if (valid_q[di] && (inc_all_q || (meta_rdata_i.rank < thr_q))) begin
      upd_word.rank = meta_rdata_i.rank + 1'b1;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    valid_d    = valid_q;
    occ_d      = occ_q;
    done_d     = 1'b0;
    cmd_d      = cmd_q;
    rsp_d      = rsp_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_rank_d = hit_rank_q;
    lru_seen_d = lru_seen_q;
    lru_idx_d  = lru_idx_q;
    lru_rank_d = lru_rank_q;
    lru_key_d  = lru_key_q;
    tgt_d      = tgt_q;
    thr_d      = thr_q;
    inc_all_d  = inc_all_q;
    ins_d      = ins_q;
    rd_hit_d   = rd_hit_q;
    evict_d    = evict_q;
    meta_req_o = '0;
    val_req_o  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d      = cmd_i;
          cnt_d      = '0;
          hit_d      = 1'b0;
          lru_seen_d = 1'b0;
          rd_hit_d   = 1'b0;
          evict_d    = 1'b0;
          state_d    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        meta_req_o.re    = !last;
        meta_req_o.raddr = cnt_q[IDX_W-1:0];
        // Read data arrives in the cycle after its address.
        if (cnt_q != '0 && valid_q[di]) begin
          if (meta_rdata_i.key == cmd_q.lookup_key) begin
            hit_d      = 1'b1;
            hit_idx_d  = di;
            hit_rank_d = meta_rdata_i.rank;
          end
          if (!lru_seen_q || (meta_rdata_i.rank > lru_rank_q)) begin
            lru_seen_d = 1'b1;
            lru_idx_d  = di;
            lru_rank_d = meta_rdata_i.rank;
            lru_key_d  = meta_rdata_i.key;
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (last) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        cnt_d = '0;
        priority if (hit_q) begin
          tgt_d     = hit_idx_q;
          thr_d     = hit_rank_q;
          inc_all_d = 1'b0;
          ins_d     = 1'b0;
          if (cmd_q.opcode == OP_PUT) begin
            val_req_o.we    = 1'b1;
            val_req_o.waddr = hit_idx_q;
            val_req_o.wdata = val_wide[DATA_WIDTH-1:0];
          end else begin
            val_req_o.re    = 1'b1;
            val_req_o.raddr = hit_idx_q;
            rd_hit_d        = 1'b1;
          end
          state_d = ST_UPDATE;
        end else if (cmd_q.opcode == OP_PUT) begin
          inc_all_d = 1'b1;
          ins_d     = 1'b1;
          thr_d     = '0;
          if (full) begin
            // The evicted entry is reused in place, so occupancy stays.
            tgt_d   = lru_idx_q;
            evict_d = 1'b1;
          end else begin
            tgt_d           = free_idx;
            valid_d[free_idx] = 1'b1;
            occ_d           = occ_q + 1'b1;
          end
          val_req_o.we    = 1'b1;
          val_req_o.waddr = full ? lru_idx_q : free_idx;
          val_req_o.wdata = val_wide[DATA_WIDTH-1:0];
          state_d = ST_UPDATE;
        end else begin
          done_d  = 1'b1;
          rsp_d   = '0;
          state_d = ST_IDLE;
        end
      end

      ST_UPDATE: begin
        meta_req_o.re    = !last;
        meta_req_o.raddr = cnt_q[IDX_W-1:0];
        meta_req_o.we    = (cnt_q != '0);
        meta_req_o.waddr = di;
        meta_req_o.wdata = upd_word;
        cnt_d = cnt_q + 1'b1;
        if (last) begin
          done_d            = 1'b1;
          rsp_d.found       = hit_q;
          rsp_d.read_value  = rd_hit_q ? $signed(rd_wide[31:0]) : '0;
          rsp_d.evicted     = evict_q;
          rsp_d.evicted_key = evict_q ? $signed(lru_key_q) : '0;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      valid_q <= '0;
      occ_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      occ_q   <= occ_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    rsp_q      <= rsp_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    hit_rank_q <= hit_rank_d;
    lru_seen_q <= lru_seen_d;
    lru_idx_q  <= lru_idx_d;
    lru_rank_q <= lru_rank_d;
    lru_key_q  <= lru_key_d;
    tgt_q      <= tgt_d;
    thr_q      <= thr_d;
    inc_all_q  <= inc_all_d;
    ins_q      <= ins_d;
    rd_hit_q   <= rd_hit_d;
    evict_q    <= evict_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: design/lru_key_value_cache_top.sv
// Top level of the LRU key/value cache: capacity register, tag and value memories, sequencer.
//
//   Channel   | Handshake            | Payload
//   ----------+----------------------+----------------------------
//   command   | start / busy         | cmd_i (opcode, key, value)
//   result    | done_o strobe        | rsp_o (found, value, evict)
//   config    | cfg_we_i             | cfg_wdata_i (capacity)
//
// Each transaction scans all MAX_ENTRIES tag entries through the single read port of the
// tag memory, then a hit or a put sweeps them again to rewrite the recency ranks.
// A get that misses gives its result after the scan and the decide state, every other
// transaction after the rank sweep that follows them; one transaction at a time.
// Reset clears the valid bits and the occupancy and sets the capacity register to
// MAX_ENTRIES; no memory clearing.
// The receiver cannot stall: done_o pulses for one cycle and busy drops with it.
`timescale 1ns / 1ps

module lru_key_value_cache_top import lkv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd_i,
  output logic             done_o,
  output rsp_t             rsp_o,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i
);

  logic [CAP_W-1:0]      cap_q, cap_d;
  meta_req_t             meta_req;
  meta_t                 meta_rdata;
  logic [$bits(meta_t)-1:0] meta_rdata_raw;
  val_req_t              val_req;
  logic [DATA_WIDTH-1:0] val_rdata;

  assign cap_d = cfg_we_i ? cfg_wdata_i : cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  lkv_ram #(
    .WIDTH($bits(meta_t)),
    .DEPTH(MAX_ENTRIES)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_req.we),
    .waddr_i(meta_req.waddr),
    .wdata_i(meta_req.wdata),
    .re_i   (meta_req.re),
    .raddr_i(meta_req.raddr),
    .rdata_o(meta_rdata_raw)
  );

  assign meta_rdata = meta_t'(meta_rdata_raw);

  lkv_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(MAX_ENTRIES)
  ) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_req.we),
    .waddr_i(val_req.waddr),
    .wdata_i(val_req.wdata),
    .re_i   (val_req.re),
    .raddr_i(val_req.raddr),
    .rdata_o(val_rdata)
  );

  lkv_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .cap_i       (cap_q),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .meta_req_o  (meta_req),
    .meta_rdata_i(meta_rdata),
    .val_req_o   (val_req),
    .val_rdata_i (val_rdata)
  );

endmodule
